/* sv/kl_pkg.sv */
// ----------------------------------------------------------------------------
// Keyed LIFO table package
// Sizes, operation and status codes, and the structures that pass between
// the sequencer, the entry store and the top level.
// ----------------------------------------------------------------------------
package kl_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned OP_W    = 2;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned ENTRY_W = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wkey;
    logic [VAL_W-1:0] wval;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [KEY_W-1:0] rkey;
    logic [VAL_W-1:0] rval;
  } mem_rsp_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [VAL_W-1:0]   found;
    logic [ENTRY_W-1:0] count;
  } res_t;

endpackage

/* sv/kl_mem.sv */
// ----------------------------------------------------------------------------
// Keyed LIFO table entry store
// Key and value arrays with one write port and one registered read port.
// ----------------------------------------------------------------------------
module kl_mem (
  input  logic             clk_i,
  input  kl_pkg::mem_req_t req_i,
  output kl_pkg::mem_rsp_t rsp_o
);
  import kl_pkg::*;

  logic [KEY_W-1:0] keys_q [DEPTH];
  logic [VAL_W-1:0] vals_q [DEPTH];
  logic [KEY_W-1:0] rkey_q;
  logic [VAL_W-1:0] rval_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      keys_q[req_i.waddr] <= req_i.wkey;
      vals_q[req_i.waddr] <= req_i.wval;
    end
    rkey_q <= keys_q[req_i.raddr];
    rval_q <= vals_q[req_i.raddr];
  end

  assign rsp_o.rkey = rkey_q;
  assign rsp_o.rval = rval_q;

endmodule

/* sv/kl_ctrl.sv */
// ----------------------------------------------------------------------------
// Keyed LIFO table sequencer
// Takes one item at a time, scans the store newest first through a single
// key comparator and closes the gap left by a delete one entry per step.
// ----------------------------------------------------------------------------
module kl_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [kl_pkg::OP_W-1:0]  operation_i,
  input  logic [kl_pkg::KEY_W-1:0] item_key_i,
  input  logic [kl_pkg::VAL_W-1:0] item_value_i,
  input  logic                     res_ready_i,
  output logic                     res_valid_o,
  output kl_pkg::res_t             res_o,
  output kl_pkg::mem_req_t         mem_req_o,
  input  kl_pkg::mem_rsp_t         mem_rsp_i
);
  import kl_pkg::*;

  localparam int unsigned CMP_W = CNT_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_SHR  = 3'd3;
  localparam logic [2:0] S_SHW  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [VAL_W-1:0]  found_q, found_d;
  logic [CMP_W-1:0]  idx_w, cnt_w;
  logic              key_hit;

  assign idx_w   = CMP_W'(idx_q);
  assign cnt_w   = CMP_W'(count_q);
  assign key_hit = (mem_rsp_i.rkey == key_q);

  always_comb begin
    state_d         = state_q;
    op_d            = op_q;
    key_d           = key_q;
    count_d         = count_q;
    idx_d           = idx_q;
    status_d        = status_q;
    found_d         = found_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = idx_q;
    mem_req_o.wkey  = mem_rsp_i.rkey;
    mem_req_o.wval  = mem_rsp_i.rval;
    mem_req_o.raddr = idx_q;
    res_valid_o     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = operation_i;
          key_d    = item_key_i;
          status_d = STAT_OK;
          found_d  = '0;
          state_d  = S_FIN;
          unique case (operation_i)
            OP_INSERT: begin
              if (count_q == CNT_W'(DEPTH)) begin
                status_d = STAT_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = IDX_W'(count_q);
                mem_req_o.wkey  = item_key_i;
                mem_req_o.wval  = item_value_i;
                count_d         = count_q + CNT_W'(1);
              end
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_DELETE, OP_LOOKUP: begin
              if (count_q == '0) begin
                status_d = STAT_MISSING;
              end else begin
                idx_d   = IDX_W'(count_q - CNT_W'(1));
                state_d = S_RD;
              end
            end
          endcase
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (key_hit) begin
          if (op_q == OP_LOOKUP) begin
            found_d = mem_rsp_i.rval;
            state_d = S_FIN;
          end else if ((idx_w + CMP_W'(1)) < cnt_w) begin
            state_d = S_SHR;
          end else begin
            count_d = count_q - CNT_W'(1);
            state_d = S_FIN;
          end
        end else if (idx_q == '0) begin
          status_d = STAT_MISSING;
          state_d  = S_FIN;
        end else begin
          idx_d   = idx_q - IDX_W'(1);
          state_d = S_RD;
        end
      end
      S_SHR: begin
        mem_req_o.raddr = idx_q + IDX_W'(1);
        state_d         = S_SHW;
      end
      S_SHW: begin
        mem_req_o.we = 1'b1;
        idx_d        = idx_q + IDX_W'(1);
        if ((idx_w + CMP_W'(2)) < cnt_w) begin
          state_d = S_SHR;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign res_o.status = status_q;
  assign res_o.found  = found_q;
  assign res_o.count  = ENTRY_W'(count_q);

endmodule

/* sv/keyed_lifo_table.sv */
// ----------------------------------------------------------------------------
// Keyed LIFO table
// A bounded key and value table kept newest first, with insert, delete,
// lookup and clear operations and one result item for every input item.
// ----------------------------------------------------------------------------
// The input channel carries an operation, a key and a value; the output
// channel returns a status, the value found by a lookup and the number of
// entries held afterwards. Both channels use valid and stall.
// One item is worked on at a time and the input is stalled meanwhile.
// Insert and clear go straight from acceptance to the result state and
// keep the input stalled until their result has been handed on.
// A lookup or delete scans from the newest entry down through one shared
// key comparator, reading and then comparing each entry examined.
// A delete then closes the gap through the single read and write port of
// the store, reading and then writing each younger entry moved.
// The next item is accepted in the cycle after its predecessor's result
// has moved into the output register, which holds it while the receiver
// stalls; a further result waits in the sequencer until that register frees.
// Reset empties the table and drops any result not yet taken; the stored
// keys and values are not cleared, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_lifo_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [kl_pkg::OP_W-1:0]     operation_i,
  input  logic [kl_pkg::KEY_W-1:0]    item_key_i,
  input  logic [kl_pkg::VAL_W-1:0]    item_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [kl_pkg::STAT_W-1:0]   status_o,
  output logic [kl_pkg::VAL_W-1:0]    found_value_o,
  output logic [kl_pkg::ENTRY_W-1:0]  entry_count_o
);
  import kl_pkg::*;

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;
  res_t     res;
  logic     res_valid;
  logic     res_ready;
  logic     out_valid_q;
  res_t     out_q;

  assign res_ready = !out_valid_q || !out_stall_i;

  kl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .item_key_i   (item_key_i),
    .item_value_i (item_value_i),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .mem_req_o    (mem_req),
    .mem_rsp_i    (mem_rsp)
  );

  kl_mem u_mem (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign found_value_o = out_q.found;
  assign entry_count_o = out_q.count;

endmodule

/* tb/keyed_lifo_table_test.sv */
// ----------------------------------------------------------------------------
// Keyed LIFO table testbench
// Drives insert, delete, lookup and clear items into the table with random
// gaps and output stalls. It keeps its own newest-first copy of the table to
// work out the status, found value and entry count of every item, and checks
// each returned item against that prediction in order.
// ----------------------------------------------------------------------------
module keyed_lifo_table_test;
  import kl_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned IDLE_PCT     = 11;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } table_req_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [OP_W-1:0]     operation_i = OP_INSERT;
  logic [KEY_W-1:0]    item_key_i = '0;
  logic [VAL_W-1:0]    item_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STAT_W-1:0]   status_o;
  logic [VAL_W-1:0]    found_value_o;
  logic [ENTRY_W-1:0]  entry_count_o;

  table_req_t          pending_reqs[$];
  table_req_t          next_req;
  res_t                table_replies[$];
  res_t                want;
  logic [KEY_W-1:0]    held_keys[DEPTH];
  logic [VAL_W-1:0]    held_values[DEPTH];
  int unsigned         held_count = 0;
  int unsigned         accepted_count = 0;
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count = 0;
  logic [KEY_W-1:0]    key_pool[8];
  logic                quiet;

  keyed_lifo_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .item_key_i    (item_key_i),
    .item_value_i  (item_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_value_o (found_value_o),
    .entry_count_o (entry_count_o)
  );

  always #5 clk_i = ~clk_i;

  // A long stretch in the middle of the run has no gaps and no stalls.
  assign quiet = (accepted_count >= 300) && (accepted_count < 550);

  function automatic res_t apply_table_op(input logic [OP_W-1:0] op,
                                          input logic [KEY_W-1:0] key,
                                          input logic [VAL_W-1:0] value);
    res_t r;
    int   slot;
    int   i;
    r.status = STAT_OK;
    r.found  = '0;
    slot = -1;
    i = int'(held_count) - 1;
    while (i >= 0 && slot < 0) begin
      if (held_keys[i] == key) slot = i;
      i--;
    end
    case (op)
      OP_INSERT: begin
        if (held_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          held_keys[held_count]   = key;
          held_values[held_count] = value;
          held_count++;
        end
      end
      OP_DELETE: begin
        if (slot < 0) begin
          r.status = STAT_MISSING;
        end else begin
          for (i = slot; i + 1 < int'(held_count); i++) begin
            held_keys[i]   = held_keys[i + 1];
            held_values[i] = held_values[i + 1];
          end
          held_count--;
        end
      end
      OP_LOOKUP: begin
        if (slot < 0) r.status = STAT_MISSING;
        else r.found = held_values[slot];
      end
      default: begin
        held_count = 0;
      end
    endcase
    r.count = held_count[ENTRY_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("cycle %0d: %s mismatch, got %h, expected %h", cycle_count, what, got,
             exp_val);
    mismatch_count++;
  endtask

  task automatic push_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
    table_req_t req;
    req.op    = op;
    req.key   = key;
    req.value = value;
    pending_reqs.push_back(req);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      operation_i  <= OP_INSERT;
      item_key_i   <= '0;
      item_value_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        table_replies.push_back(apply_table_op(operation_i, item_key_i, item_value_i));
        accepted_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          next_req = pending_reqs.pop_front();
          in_valid_i   <= 1'b1;
          operation_i  <= next_req.op;
          item_key_i   <= next_req.key;
          item_value_i <= next_req.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (table_replies.size() == 0) begin
          report_mismatch("unexpected item", {30'd0, status_o}, '0);
        end else begin
          want = table_replies.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
          if (found_value_o !== want.found)
            report_mismatch("found value", found_value_o, want.found);
          if (entry_count_o !== want.count)
            report_mismatch("entry count", 32'(entry_count_o), 32'(want.count));
        end
      end
      out_stall_i <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned produced;
    int unsigned mode;
    int unsigned roll;
    int unsigned ins_lim;
    int unsigned del_lim;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;

    // Empty table, extreme keys and values, duplicates and misses.
    push_item(OP_LOOKUP, 32'h0000_0000, $urandom);
    push_item(OP_DELETE, 32'hFFFF_FFFF, $urandom);
    push_item(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    push_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    push_item(OP_INSERT, 32'h0000_0005, 32'h0000_0001);
    push_item(OP_INSERT, 32'h0000_0005, 32'h0000_0002);
    push_item(OP_LOOKUP, 32'h0000_0005, $urandom);
    push_item(OP_DELETE, 32'h0000_0005, $urandom);
    push_item(OP_LOOKUP, 32'h0000_0005, $urandom);
    push_item(OP_DELETE, 32'h0000_0123, $urandom);
    push_item(OP_LOOKUP, 32'h0000_0000, $urandom);
    push_item(OP_LOOKUP, 32'hFFFF_FFFF, $urandom);
    push_item(OP_LOOKUP, 32'hAAAA_5555, $urandom);
    push_item(OP_DELETE, 32'h0000_0000, $urandom);
    push_item(OP_CLEAR, $urandom, $urandom);
    push_item(OP_LOOKUP, 32'hFFFF_FFFF, $urandom);
    push_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Blocks lean towards filling, draining or a mix, with keys mostly from
    // a small pool so that duplicates, hits and a full table are common.
    produced = 0;
    while (produced < RANDOM_ITEMS) begin
      mode = $urandom_range(2);
      ins_lim = (mode == 0) ? 65 : (mode == 1) ? 25 : 40;
      del_lim = (mode == 0) ? 75 : (mode == 1) ? 65 : 60;
      foreach (key_pool[k]) key_pool[k] = $urandom;
      repeat (40) begin
        roll = $urandom_range(99);
        if (roll < ins_lim) op = OP_INSERT;
        else if (roll < del_lim) op = OP_DELETE;
        else if (roll < 97) op = OP_LOOKUP;
        else op = OP_CLEAR;
        key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(7)] : $urandom;
        push_item(op, key, $urandom);
        produced++;
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || in_valid_i || table_replies.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (table_replies.size() != 0)
      report_mismatch("missing items", table_replies.size(), 0);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
